// ----- src/bms_pkg.sv -----
// Shared types, register indexes and constants for the battery mode selector.
package bms_pkg;

	// Weight of the previous average, Q1.16; this value stands for one.
	localparam int unsigned WeightW   = 17;
	localparam int unsigned LevelW    = 16;
	localparam int unsigned CfgIndexW = 3;
	localparam logic [WeightW-1:0] WEIGHT_ONE = 17'h10000;

	// Power modes, ordered from lowest to highest supply.
	typedef enum logic [1:0] {
		MODE_CRITICAL = 2'd0,
		MODE_SAFE     = 2'd1,
		MODE_CRUISE   = 2'd2,
		MODE_FULL     = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CfgIndexW-1:0] {
		REG_SMOOTHING_WEIGHT  = 3'd0,
		REG_UP_FULL_LEVEL     = 3'd1,
		REG_UP_CRUISE_LEVEL   = 3'd2,
		REG_UP_SAFE_LEVEL     = 3'd3,
		REG_DOWN_SAFE_LEVEL   = 3'd4,
		REG_DOWN_CRUISE_LEVEL = 3'd5,
		REG_DOWN_FULL_LEVEL   = 3'd6
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [WeightW-1:0] RST_SMOOTHING_WEIGHT  = 17'd32768;
	localparam logic [LevelW-1:0]  RST_UP_FULL_LEVEL     = 16'd7300;
	localparam logic [LevelW-1:0]  RST_UP_CRUISE_LEVEL   = 16'd7100;
	localparam logic [LevelW-1:0]  RST_UP_SAFE_LEVEL     = 16'd6600;
	localparam logic [LevelW-1:0]  RST_DOWN_SAFE_LEVEL   = 16'd6500;
	localparam logic [LevelW-1:0]  RST_DOWN_CRUISE_LEVEL = 16'd7000;
	localparam logic [LevelW-1:0]  RST_DOWN_FULL_LEVEL   = 16'd7200;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [WeightW-1:0] smoothing_weight;
		logic [LevelW-1:0]  up_full_level;
		logic [LevelW-1:0]  up_cruise_level;
		logic [LevelW-1:0]  up_safe_level;
		logic [LevelW-1:0]  down_safe_level;
		logic [LevelW-1:0]  down_cruise_level;
		logic [LevelW-1:0]  down_full_level;
	} cfg_t;

	// One result item plus the state it leaves behind.
	typedef struct packed {
		logic [LevelW-1:0] filtered_level;
		mode_t             power_mode;
		logic              mode_changed;
		logic              charging;
	} result_t;

endpackage

// ----- src/bms_core.sv -----
// Moving average filter and hysteresis mode decision for one sample.
module bms_core (
	input  bms_pkg::cfg_t                 cfg,
	input  logic [bms_pkg::LevelW-1:0]    sample,
	input  logic                          seed,
	input  logic [bms_pkg::LevelW-1:0]    last_level,
	input  bms_pkg::mode_t                cur_mode,
	output bms_pkg::result_t              result
);
	import bms_pkg::*;

	logic [WeightW-1:0]   w_sat;
	logic [WeightW-1:0]   w_inv;
	logic [LevelW-1:0]    prev;
	logic [WeightW+LevelW-1:0] prod_prev;
	logic [WeightW+LevelW-1:0] prod_sample;
	logic [WeightW+LevelW-1:0] acc;
	logic [LevelW-1:0]    avg;
	logic                 rising;
	mode_t                mode_nxt;

	// Weight above one saturates to one
	assign w_sat = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
	assign w_inv = WEIGHT_ONE - w_sat;

	// Seeding replaces the previous average with the sample
	assign prev = seed ? sample : last_level;

	// Weighted sum stays below 2^32, truncate to the integer part
	assign prod_prev   = {{(LevelW){1'b0}}, w_sat} * {{(WeightW){1'b0}}, prev};
	assign prod_sample = {{(LevelW){1'b0}}, w_inv} * {{(WeightW){1'b0}}, sample};
	assign acc         = prod_prev + prod_sample;
	assign avg         = acc[LevelW +: LevelW];

	assign rising = (avg >= prev);

	// Highest up level when rising, lowest down level when falling
	always_comb begin
		mode_nxt = cur_mode;
		if (rising) begin
			if (avg >= cfg.up_full_level)
				mode_nxt = MODE_FULL;
			else if (avg >= cfg.up_cruise_level)
				mode_nxt = MODE_CRUISE;
			else if (avg >= cfg.up_safe_level)
				mode_nxt = MODE_SAFE;
		end else begin
			if (avg <= cfg.down_safe_level)
				mode_nxt = MODE_CRITICAL;
			else if (avg <= cfg.down_cruise_level)
				mode_nxt = MODE_SAFE;
			else if (avg <= cfg.down_full_level)
				mode_nxt = MODE_CRUISE;
		end
	end

	assign result.filtered_level = avg;
	assign result.power_mode     = mode_nxt;
	assign result.mode_changed   = (mode_nxt != cur_mode);
	assign result.charging       = rising;

endmodule

// ----- src/battery_mode_selector.sv -----
// Battery mode selector: smoothed voltage and hysteresis power mode selection.
// Pipeline: an accepted sample passes the input register, then the result register.
// Throughput: one item per cycle while out_ready stays high; filter and mode are combinational between them.
// Reset: asynchronous, active low; average clears to zero, mode to safe,
// configuration registers to their default levels, both stages empty.
module battery_mode_selector (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [bms_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [bms_pkg::WeightW-1:0]       cfg_data,
	// sample channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bms_pkg::LevelW-1:0]        battery_sample,
	input  logic                              seed_average,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bms_pkg::LevelW-1:0]        filtered_level,
	output logic [1:0]                        power_mode,
	output logic                              mode_changed,
	output logic                              charging
);
	import bms_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [LevelW-1:0] sample_s1;
	logic              seed_s1;
	logic              out_valid_q;
	result_t           res_q;
	logic [LevelW-1:0] last_level_q;
	mode_t             mode_q;
	result_t           res_nxt;
	logic              advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_weight  <= RST_SMOOTHING_WEIGHT;
			cfg_q.up_full_level     <= RST_UP_FULL_LEVEL;
			cfg_q.up_cruise_level   <= RST_UP_CRUISE_LEVEL;
			cfg_q.up_safe_level     <= RST_UP_SAFE_LEVEL;
			cfg_q.down_safe_level   <= RST_DOWN_SAFE_LEVEL;
			cfg_q.down_cruise_level <= RST_DOWN_CRUISE_LEVEL;
			cfg_q.down_full_level   <= RST_DOWN_FULL_LEVEL;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SMOOTHING_WEIGHT:  cfg_q.smoothing_weight  <= cfg_data;
				REG_UP_FULL_LEVEL:     cfg_q.up_full_level     <= cfg_data[LevelW-1:0];
				REG_UP_CRUISE_LEVEL:   cfg_q.up_cruise_level   <= cfg_data[LevelW-1:0];
				REG_UP_SAFE_LEVEL:     cfg_q.up_safe_level     <= cfg_data[LevelW-1:0];
				REG_DOWN_SAFE_LEVEL:   cfg_q.down_safe_level   <= cfg_data[LevelW-1:0];
				REG_DOWN_CRUISE_LEVEL: cfg_q.down_cruise_level <= cfg_data[LevelW-1:0];
				REG_DOWN_FULL_LEVEL:   cfg_q.down_full_level   <= cfg_data[LevelW-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: the input stage moves on when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= battery_sample;
			seed_s1   <= seed_average;
		end
	end

	bms_core u_core (
		.cfg        (cfg_q),
		.sample     (sample_s1),
		.seed       (seed_s1),
		.last_level (last_level_q),
		.cur_mode   (mode_q),
		.result     (res_nxt)
	);

	// Filter state follows each item as it reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			mode_q       <= MODE_SAFE;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				last_level_q <= res_nxt.filtered_level;
				mode_q       <= res_nxt.power_mode;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign filtered_level = res_q.filtered_level;
	assign power_mode     = res_q.power_mode;
	assign mode_changed   = res_q.mode_changed;
	assign charging       = res_q.charging;

`ifndef SYNTH
	// A held result always matches the filter state it left behind
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.filtered_level == last_level_q) && (res_q.power_mode == mode_q))
		else $error("result register disagrees with filter state");

	// The change flag reports exactly a move of the held mode
	a_change_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_q.mode_changed == (mode_q != $past(mode_q)))
		else $error("mode change flag does not match mode update");

	// Without seeding, charging compares against the earlier average
	a_charging: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !seed_s1 |=> res_q.charging == (last_level_q >= $past(last_level_q)))
		else $error("charging flag does not match average trend");

	// The input stage never drops an item it cannot hand on
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1) && $stable(seed_s1))
		else $error("input stage lost a stalled item");
`endif

endmodule
